FILE: hw/rtl/tte_pkg.sv
// Shared types and constants for the transposition table engine.
// Used by the table memory, the index unit, the core and the checker.
`default_nettype none

package tte_pkg;

  localparam int unsigned KEY_W      = 64;
  localparam int unsigned MOVE_W     = 25;
  localparam int unsigned SCORE_W    = 16;
  localparam int unsigned DEPTH_W    = 6;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned PLY_W      = 6;
  localparam int unsigned AGE_W      = 16;
  localparam int unsigned THR_W      = 15;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam int unsigned ENTRIES_DEF      = 65536;
  localparam int unsigned SCORE_OFFSET_DEF = 32000;

  localparam logic [THR_W-1:0] MATE_THR_RST = THR_W'(29000);

  // item modes
  localparam logic [MODE_W-1:0] MODE_STORE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PROBE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BEST  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd3;

  // bound kinds
  localparam logic [KIND_W-1:0] KIND_UPPER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOWER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXACT = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_AGE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATE_THRESHOLD = 1'b1;

  // one table entry; bit 22 of the packed word is always zero and is not kept
  typedef struct packed {
    logic [KEY_W-1:0]   check;
    logic [AGE_W-1:0]   age;
    logic [MOVE_W-1:0]  move;
    logic [KIND_W-1:0]  kind;
    logic [DEPTH_W-1:0] depth;
    logic [SCORE_W-1:0] score;
  } tte_entry_t;

  // rebuild the 64-bit packed word from the kept fields
  function automatic logic [KEY_W-1:0] packed_word(input tte_entry_t e);
    return {14'd0, e.move, e.kind, 1'b0, e.depth, e.score};
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/tte_table.sv
// Single-port-write, single-port-read synchronous table with registered read.
// Depends on tte_pkg for the entry type.
`default_nettype none

module tte_table #(
  parameter int unsigned DEPTH  = tte_pkg::ENTRIES_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                clk_i,
  input  wire logic                we_i,
  input  wire logic [ADDR_W-1:0]   waddr_i,
  input  wire tte_pkg::tte_entry_t wdata_i,
  input  wire logic                re_i,
  input  wire logic [ADDR_W-1:0]   raddr_i,
  output tte_pkg::tte_entry_t      rdata_o
);

  tte_pkg::tte_entry_t mem_q [DEPTH];
  tte_pkg::tte_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tte_index.sv
// Maps a 64-bit key to a table index (key modulo ENTRIES).
// Power-of-two sizes use the low bits at once; others register a fold sum, then reduce.
`default_nettype none

module tte_index #(
  parameter int unsigned ENTRIES = tte_pkg::ENTRIES_DEF,
  parameter int unsigned IDX_W   = $clog2(ENTRIES)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [tte_pkg::KEY_W-1:0] key_i,
  output logic                           done_o,
  output logic [IDX_W-1:0]               idx_o
);

  localparam bit IS_POW2 = (ENTRIES & (ENTRIES - 1)) == 0;

  if (IS_POW2) begin : g_mask
    assign done_o = start_i;
    assign idx_o  = key_i[IDX_W-1:0];
  end else begin : g_fold
    // key mod N = (sum over bytes of byte * (2^(8j) mod N)) mod N
    localparam int unsigned BYTES  = tte_pkg::KEY_W / 8;
    localparam int unsigned SUM_W  = IDX_W + 11;
    localparam int unsigned SHIFT  = SUM_W + IDX_W;
    localparam int unsigned PROD_W = 2 * SUM_W + 1;
    localparam int unsigned QUOT_W = SUM_W - IDX_W + 1;
    localparam logic [SUM_W:0] RECIP   = (SUM_W+1)'((64'd1 << SHIFT) / 64'(ENTRIES));
    localparam logic [IDX_W:0] MODULUS = (IDX_W+1)'(ENTRIES);

    logic [SUM_W-1:0]  part [BYTES];
    logic [SUM_W-1:0]  sum_d;
    logic [SUM_W-1:0]  sum_q;
    logic [SUM_W-1:0]  sum2_q;
    logic [PROD_W-1:0] prod;
    logic [QUOT_W-1:0] quot_d;
    logic [QUOT_W-1:0] quot_q;
    logic [SUM_W-1:0]  rem_wide;
    logic [IDX_W:0]    rem_fix;
    logic [IDX_W:0]    rem_sub;
    logic              v1_q;
    logic              v2_q;

    for (genvar j = 0; j < BYTES; j++) begin : g_part
      localparam logic [IDX_W-1:0] WEIGHT = IDX_W'((64'd1 << (8 * j)) % 64'(ENTRIES));
      assign part[j] = SUM_W'(key_i[8*j +: 8]) * SUM_W'(WEIGHT);
    end

    always_comb begin
      sum_d = '0;
      for (int j = 0; j < BYTES; j++) begin
        sum_d = sum_d + part[j];
      end
    end

    // quotient by reciprocal multiply, at most one short; one compare and subtract fixes it
    assign prod     = PROD_W'(sum_q) * PROD_W'(RECIP);
    assign quot_d   = prod[SHIFT +: QUOT_W];
    assign rem_wide = sum2_q - SUM_W'(quot_q) * SUM_W'(MODULUS);
    assign rem_fix  = rem_wide[IDX_W:0];
    assign rem_sub  = rem_fix - MODULUS;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v1_q <= 1'b0;
        v2_q <= 1'b0;
      end else begin
        v1_q <= start_i;
        v2_q <= v1_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        sum_q <= sum_d;
      end
      if (v1_q) begin
        sum2_q <= sum_q;
        quot_q <= quot_d;
      end
    end

    assign done_o = v2_q;
    assign idx_o  = (rem_fix >= MODULUS) ? rem_sub[IDX_W-1:0] : rem_fix[IDX_W-1:0];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/transposition_table_engine_core.sv
// Transposition table engine: direct-mapped hash table with lockless check words.
// Each item is hashed to an index, read from the table and then evaluated, with write-back on
// the one table; for power-of-two ENTRIES the index is taken at once, otherwise it comes from
// key folding and reciprocal reduction. A new item is accepted only in the idle state, after the
// last one was evaluated; a held result stalls the next item. Reset and a clear item start a
// clearing pass that zeroes every entry of the table; in_ready_o stays low during it.
`default_nettype none

module transposition_table_engine_core #(
  parameter int unsigned ENTRIES      = tte_pkg::ENTRIES_DEF,
  parameter int unsigned SCORE_OFFSET = tte_pkg::SCORE_OFFSET_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // configuration
  input  wire logic                            cfg_we_i,
  input  wire logic [tte_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tte_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // input items
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [tte_pkg::MODE_W-1:0]      mode_i,
  input  wire logic [tte_pkg::KEY_W-1:0]       position_key_i,
  input  wire logic [tte_pkg::MOVE_W-1:0]      move_in_i,
  input  wire logic signed [tte_pkg::SCORE_W-1:0] score_in_i,
  input  wire logic [tte_pkg::KIND_W-1:0]      bound_kind_i,
  input  wire logic [tte_pkg::DEPTH_W-1:0]     search_depth_i,
  input  wire logic signed [tte_pkg::SCORE_W-1:0] window_low_i,
  input  wire logic signed [tte_pkg::SCORE_W-1:0] window_high_i,
  input  wire logic [tte_pkg::PLY_W-1:0]       ply_i,
  // result items
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 key_matched_o,
  output logic [tte_pkg::MOVE_W-1:0]           move_out_o,
  output logic                                 cutoff_o,
  output logic signed [tte_pkg::SCORE_W-1:0]   score_out_o,
  output logic                                 stored_o,
  output logic [tte_pkg::CNT_W-1:0]            hit_count_o,
  output logic [tte_pkg::CNT_W-1:0]            new_write_count_o
);

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam int unsigned SW    = 18;  // working width for score arithmetic
  localparam logic signed [SW-1:0] OFFSET   = SW'(SCORE_OFFSET);
  localparam logic signed [SW-1:0] SLOT_MAX = SW'(65535);
  localparam logic signed [SW-1:0] S16_MAX  = SW'(32767);
  localparam logic signed [SW-1:0] S16_MIN  = -SW'(32768);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_HASH  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;
  localparam logic [1:0] ST_SWEEP = 2'd3;

  logic [1:0] state_q, state_d;
  logic [IDX_W-1:0] sweep_q, sweep_d;
  logic [IDX_W-1:0] idx_q;

  // item held for evaluation
  logic [tte_pkg::MODE_W-1:0]  mode_q;
  logic [tte_pkg::KEY_W-1:0]   key_q;
  logic [tte_pkg::MOVE_W-1:0]  move_q;
  logic [tte_pkg::SCORE_W-1:0] score_q;
  logic [tte_pkg::KIND_W-1:0]  kind_q;
  logic [tte_pkg::DEPTH_W-1:0] depth_q;
  logic [tte_pkg::SCORE_W-1:0] alpha_q;
  logic [tte_pkg::SCORE_W-1:0] beta_q;
  logic [tte_pkg::PLY_W-1:0]   ply_q;

  logic [tte_pkg::AGE_W-1:0] cur_age_q, cur_age_d;
  logic [tte_pkg::THR_W-1:0] mate_thr_q, mate_thr_d;
  logic [tte_pkg::CNT_W-1:0] hits_q, hits_d;
  logic [tte_pkg::CNT_W-1:0] new_writes_q, new_writes_d;

  // result register
  logic                         out_valid_q, out_valid_d;
  logic                         res_matched_q, res_matched_d;
  logic [tte_pkg::MOVE_W-1:0]   res_move_q, res_move_d;
  logic                         res_cut_q, res_cut_d;
  logic [tte_pkg::SCORE_W-1:0]  res_score_q, res_score_d;
  logic                         res_stored_q, res_stored_d;
  logic [tte_pkg::CNT_W-1:0]    res_hits_q;
  logic [tte_pkg::CNT_W-1:0]    res_new_q;

  logic in_accept;
  logic idx_done;
  logic [IDX_W-1:0] idx_calc;
  logic eval_go;

  tte_pkg::tte_entry_t rd_ent;
  tte_pkg::tte_entry_t wr_ent;
  tte_pkg::tte_entry_t new_ent;
  logic                tbl_we;
  logic [IDX_W-1:0]    tbl_waddr;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign eval_go    = (state_q == ST_EVAL) && (!out_valid_q || out_ready_i);

  tte_index #(
    .ENTRIES (ENTRIES),
    .IDX_W   (IDX_W)
  ) u_index (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .key_i   (position_key_i),
    .done_o  (idx_done),
    .idx_o   (idx_calc)
  );

  tte_table #(
    .DEPTH  (ENTRIES),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (wr_ent),
    .re_i    (idx_done),
    .raddr_i (idx_calc),
    .rdata_o (rd_ent)
  );

  // ---------------------------------------------------------------- entry tests
  logic [tte_pkg::KEY_W-1:0] rd_packed;
  logic is_empty, key_hit, depth_ok, replace;

  assign rd_packed = tte_pkg::packed_word(rd_ent);
  assign is_empty  = (rd_ent.check == '0);
  assign key_hit   = (rd_ent.check == (key_q ^ rd_packed));
  assign depth_ok  = (rd_ent.depth >= depth_q);
  assign replace   = is_empty || (rd_ent.age < cur_age_q) || (rd_ent.depth < depth_q);

  logic signed [SW-1:0] thr_s;
  logic signed [SW-1:0] ply_s;
  assign thr_s = SW'(mate_thr_q);
  assign ply_s = SW'(ply_q);

  // ---------------------------------------------------------------- store score
  // push mate scores away from zero, offset into the slot, saturate to 16 bits
  logic signed [SW-1:0] st_score;
  logic signed [SW-1:0] st_ply;
  logic signed [SW-1:0] st_adj;
  logic [tte_pkg::SCORE_W-1:0] st_slot;

  assign st_score = SW'($signed(score_q));

  always_comb begin
    if (st_score > thr_s) begin
      st_ply = ply_s;
    end else if (st_score < -thr_s) begin
      st_ply = -ply_s;
    end else begin
      st_ply = '0;
    end
    st_adj = st_score + OFFSET + st_ply;
    if (st_adj < 0) begin
      st_slot = '0;
    end else if (st_adj > SLOT_MAX) begin
      st_slot = '1;
    end else begin
      st_slot = st_adj[tte_pkg::SCORE_W-1:0];
    end
  end

  always_comb begin
    new_ent       = '0;
    new_ent.score = st_slot;
    new_ent.depth = depth_q;
    new_ent.kind  = kind_q;
    new_ent.move  = move_q;
    new_ent.age   = cur_age_q;
    new_ent.check = key_q ^ tte_pkg::packed_word(new_ent);
  end

  // ---------------------------------------------------------------- probe score
  logic signed [SW-1:0] pr_raw;
  logic signed [SW-1:0] pr_adj;
  logic [tte_pkg::SCORE_W-1:0] pr_score;
  logic pr_cut;
  logic [tte_pkg::SCORE_W-1:0] pr_out;

  assign pr_raw = SW'(rd_ent.score) - OFFSET;

  always_comb begin
    if (pr_raw > thr_s) begin
      pr_adj = pr_raw - ply_s;
    end else if (pr_raw < -thr_s) begin
      pr_adj = pr_raw + ply_s;
    end else begin
      pr_adj = pr_raw;
    end
    if (pr_adj > S16_MAX) begin
      pr_score = S16_MAX[tte_pkg::SCORE_W-1:0];
    end else if (pr_adj < S16_MIN) begin
      pr_score = S16_MIN[tte_pkg::SCORE_W-1:0];
    end else begin
      pr_score = pr_adj[tte_pkg::SCORE_W-1:0];
    end

    pr_cut = 1'b0;
    pr_out = pr_score;
    case (rd_ent.kind)
      tte_pkg::KIND_UPPER: begin
        if ($signed(pr_score) <= $signed(alpha_q)) begin
          pr_cut = 1'b1;
          pr_out = alpha_q;
        end
      end
      tte_pkg::KIND_LOWER: begin
        if ($signed(pr_score) >= $signed(beta_q)) begin
          pr_cut = 1'b1;
          pr_out = beta_q;
        end
      end
      tte_pkg::KIND_EXACT: begin
        pr_cut = 1'b1;
      end
      default: begin
        pr_cut = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------- evaluate
  always_comb begin
    hits_d        = hits_q;
    new_writes_d  = new_writes_q;
    cur_age_d     = cur_age_q;
    mate_thr_d    = mate_thr_q;
    res_matched_d = 1'b0;
    res_move_d    = '0;
    res_cut_d     = 1'b0;
    res_score_d   = '0;
    res_stored_d  = 1'b0;

    if (eval_go) begin
      case (mode_q)
        tte_pkg::MODE_STORE: begin
          res_stored_d = replace;
          if (is_empty) begin
            new_writes_d = new_writes_q + tte_pkg::CNT_W'(1);
          end
        end
        tte_pkg::MODE_PROBE: begin
          if (key_hit) begin
            res_matched_d = 1'b1;
            res_move_d    = rd_ent.move;
            if (depth_ok) begin
              hits_d      = hits_q + tte_pkg::CNT_W'(1);
              res_cut_d   = pr_cut;
              res_score_d = pr_out;
            end
          end
        end
        tte_pkg::MODE_BEST: begin
          if (key_hit) begin
            res_matched_d = 1'b1;
            res_move_d    = rd_ent.move;
          end
        end
        tte_pkg::MODE_CLEAR: begin
          new_writes_d = '0;
          cur_age_d    = '0;
        end
        default: begin
          res_stored_d = 1'b0;
        end
      endcase
    end

    if (cfg_we_i) begin
      case (cfg_index_i)
        tte_pkg::CFG_CURRENT_AGE:    cur_age_d  = cfg_data_i[tte_pkg::AGE_W-1:0];
        tte_pkg::CFG_MATE_THRESHOLD: mate_thr_d = cfg_data_i[tte_pkg::THR_W-1:0];
        default:                     cur_age_d  = cur_age_q;
      endcase
    end
  end

  // table write: zero during the clearing pass, else a replacing store
  always_comb begin
    if (state_q == ST_SWEEP) begin
      tbl_we    = 1'b1;
      tbl_waddr = sweep_q;
      wr_ent    = '0;
    end else begin
      tbl_we    = eval_go && (mode_q == tte_pkg::MODE_STORE) && replace;
      tbl_waddr = idx_q;
      wr_ent    = new_ent;
    end
  end

  // ---------------------------------------------------------------- sequencing
  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = idx_done ? ST_EVAL : ST_HASH;
        end
      end
      ST_HASH: begin
        if (idx_done) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (eval_go) begin
          if (mode_q == tte_pkg::MODE_CLEAR) begin
            state_d = ST_SWEEP;
            sweep_d = '0;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SWEEP: begin
        sweep_d = sweep_q + IDX_W'(1);
        if (sweep_q == IDX_W'(ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (eval_go) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_SWEEP;
      sweep_q      <= '0;
      out_valid_q  <= 1'b0;
      cur_age_q    <= '0;
      mate_thr_q   <= tte_pkg::MATE_THR_RST;
      hits_q       <= '0;
      new_writes_q <= '0;
    end else begin
      state_q      <= state_d;
      sweep_q      <= sweep_d;
      out_valid_q  <= out_valid_d;
      cur_age_q    <= cur_age_d;
      mate_thr_q   <= mate_thr_d;
      hits_q       <= hits_d;
      new_writes_q <= new_writes_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q  <= mode_i;
      key_q   <= position_key_i;
      move_q  <= move_in_i;
      score_q <= score_in_i;
      kind_q  <= bound_kind_i;
      depth_q <= search_depth_i;
      alpha_q <= window_low_i;
      beta_q  <= window_high_i;
      ply_q   <= ply_i;
    end
    if (idx_done) begin
      idx_q <= idx_calc;
    end
    if (eval_go) begin
      res_matched_q <= res_matched_d;
      res_move_q    <= res_move_d;
      res_cut_q     <= res_cut_d;
      res_score_q   <= res_score_d;
      res_stored_q  <= res_stored_d;
      res_hits_q    <= hits_d;
      res_new_q     <= new_writes_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign key_matched_o     = res_matched_q;
  assign move_out_o        = res_move_q;
  assign cutoff_o          = res_cut_q;
  assign score_out_o       = res_score_q;
  assign stored_o          = res_stored_q;
  assign hit_count_o       = res_hits_q;
  assign new_write_count_o = res_new_q;

endmodule

`default_nettype wire

FILE: hw/rtl/tte_checker.sv
// Port-level checks for the transposition table engine core, bound to the core module.
// Depends on tte_pkg for field widths.
`default_nettype none

module tte_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              in_ready_o,
  input wire logic                              out_valid_o,
  input wire logic                              out_ready_i,
  input wire logic                              key_matched_o,
  input wire logic                              cutoff_o,
  input wire logic signed [tte_pkg::SCORE_W-1:0] score_out_o,
  input wire logic                              stored_o,
  input wire logic [tte_pkg::CNT_W-1:0]         hit_count_o
);

  logic                      seen_q;
  logic [tte_pkg::CNT_W-1:0] last_hits_q;
  logic [tte_pkg::CNT_W-1:0] hit_step;
  logic                      out_take;

  assign out_take = out_valid_o && out_ready_i;
  assign hit_step = hit_count_o - last_hits_q;

  // remember the hit count of the last item taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      last_hits_q <= '0;
    end else if (out_take) begin
      seen_q      <= 1'b1;
      last_hits_q <= hit_count_o;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  a_busy_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !in_ready_o)
    else $error("input taken before the clearing pass");

  a_cut_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cutoff_o |-> key_matched_o)
    else $error("cutoff without a key match");

  a_store_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && stored_o |-> !key_matched_o && !cutoff_o && (score_out_o == '0))
    else $error("store result carries probe fields");

  a_hit_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && seen_q |-> (hit_step == '0) || (hit_step == tte_pkg::CNT_W'(1)))
    else $error("hit count moved by more than one per item");

endmodule

bind transposition_table_engine_core tte_checker u_tte_checker (.*);

`default_nettype wire
